// ----- sv/slrp_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the server list response parser
package slrp_pkg;

  localparam logic [7:0]  SEPARATOR  = 8'h5C;
  localparam logic [23:0] EOT_WORD   = 24'h454F54;
  localparam logic [8:0]  HARD_LIMIT = 9'd256;
  localparam int          QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    PH_SEEK  = 4'd0,
    PH_ADDR0 = 4'd1,
    PH_ADDR1 = 4'd2,
    PH_ADDR2 = 4'd3,
    PH_ADDR3 = 4'd4,
    PH_QP0   = 4'd5,
    PH_QP1   = 4'd6,
    PH_GP0   = 4'd7,
    PH_GP1   = 4'd8,
    PH_CHECK = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    CAUSE_END    = 2'd0,
    CAUSE_EOT    = 2'd1,
    CAUSE_SYNTAX = 2'd2,
    CAUSE_LIMIT  = 2'd3
  } cause_t;

  // one classified payload byte on its way to the parser
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_sep;
  } item_t;

endpackage

// ----- sv/slrp_front.sv -----
`timescale 1ns / 1ps
// input side: takes request bytes and tags separators for the parser
module slrp_front import slrp_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.data   = in_data_byte;
    q_item.last   = in_last_byte;
    q_item.is_sep = (in_data_byte == SEPARATOR);
  end

endmodule

// ----- sv/slrp_queue.sv -----
`timescale 1ns / 1ps
// two-entry queue between the input side and the parser
module slrp_queue import slrp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CntW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/slrp_back.sv -----
`timescale 1ns / 1ps
// parser: record state machine, record limit and the registered result
module slrp_back import slrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_valid,
  output logic [31:0] out_server_ip,
  output logic [15:0] out_query_port,
  output logic [15:0] out_game_port,
  output logic [8:0]  out_record_count,
  output logic        out_packet_done,
  output logic [1:0]  out_stop_reason
);

  logic [8:0]  max_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] qp_r, qp_nxt;
  logic [15:0] gp_r, gp_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic        halted_r, halted_nxt;
  cause_t      cause_r, cause_nxt;
  logic        after_r, after_nxt;

  logic        out_valid_r;
  logic        rec_r;
  logic [31:0] ip_r;
  logic [15:0] oqp_r, ogp_r;
  logic [8:0]  ocnt_r;
  logic        done_r;
  logic [1:0]  reason_r;

  logic        step;
  logic        rec;
  logic        emit;
  logic [8:0]  limit;
  logic [8:0]  cnt_inc;
  logic [8:0]  rec_count;
  logic [1:0]  reason;
  logic [7:0]  b;

  assign b       = head_item.data;
  assign limit   = (max_r > HARD_LIMIT) ? HARD_LIMIT : max_r;
  assign cnt_inc = cnt_r + 9'd1;
  assign step    = head_valid && (!out_valid_r || !out_stall);
  assign pop     = step;

  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    qp_nxt     = qp_r;
    gp_nxt     = gp_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    cause_nxt  = cause_r;
    after_nxt  = after_r;
    rec        = 1'b0;

    if (!halted_r) begin
      unique case (phase_r)
        PH_SEEK: begin
          if (head_item.is_sep) begin
            phase_nxt = PH_ADDR0;
          end
        end
        PH_ADDR0, PH_ADDR1, PH_ADDR3: begin
          addr_nxt  = {addr_r[23:0], b};
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
        PH_ADDR2: begin
          addr_nxt  = {addr_r[23:0], b};
          // eot only counts right after a completed record
          if (after_r && ({addr_r[15:0], b} == EOT_WORD)) begin
            halted_nxt = 1'b1;
            cause_nxt  = CAUSE_EOT;
          end
          after_nxt = 1'b0;
          phase_nxt = PH_ADDR3;
        end
        PH_QP0, PH_QP1: begin
          qp_nxt    = {qp_r[7:0], b};
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
        PH_GP0, PH_GP1: begin
          gp_nxt    = {gp_r[7:0], b};
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
        PH_CHECK: begin
          if (!head_item.is_sep) begin
            halted_nxt = 1'b1;
            cause_nxt  = CAUSE_SYNTAX;
          end else begin
            cnt_nxt = cnt_inc;
            rec     = 1'b1;
            if (cnt_inc >= limit) begin
              halted_nxt = 1'b1;
              cause_nxt  = CAUSE_LIMIT;
            end else begin
              // closing separator opens the next record
              after_nxt = 1'b1;
              phase_nxt = PH_ADDR0;
            end
          end
        end
        default: begin
          phase_nxt = PH_SEEK;
        end
      endcase
    end

    emit      = rec || head_item.last;
    rec_count = cnt_nxt;
    reason    = (head_item.last && halted_nxt) ? cause_nxt : CAUSE_END;

    if (head_item.last) begin
      phase_nxt  = PH_SEEK;
      addr_nxt   = '0;
      qp_nxt     = '0;
      gp_nxt     = '0;
      cnt_nxt    = '0;
      halted_nxt = 1'b0;
      cause_nxt  = CAUSE_END;
      after_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= HARD_LIMIT;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      addr_r   <= '0;
      qp_r     <= '0;
      gp_r     <= '0;
      cnt_r    <= '0;
      halted_r <= 1'b0;
      cause_r  <= CAUSE_END;
      after_r  <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      qp_r     <= qp_nxt;
      gp_r     <= gp_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
      cause_r  <= cause_nxt;
      after_r  <= after_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      rec_r    <= rec;
      ip_r     <= rec ? addr_r : 32'd0;
      oqp_r    <= rec ? qp_r : 16'd0;
      ogp_r    <= rec ? gp_r : 16'd0;
      ocnt_r   <= rec_count;
      done_r   <= head_item.last;
      reason_r <= reason;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_valid = rec_r;
  assign out_server_ip    = ip_r;
  assign out_query_port   = oqp_r;
  assign out_game_port    = ogp_r;
  assign out_record_count = ocnt_r;
  assign out_packet_done  = done_r;
  assign out_stop_reason  = reason_r;

endmodule

// ----- sv/server_list_response_parser.sv -----
`timescale 1ns / 1ps
// top level of the server list response parser
//
// Takes one list packet byte per request and gives a result for every
// completed server record (address, query port, game port, running count)
// and one on the packet's last byte with the stop reason: end of data, EOT
// marker, syntax error or record limit. A byte can be taken every clock
// cycle while in_stall is low; a request is tagged at the input, written
// into a two-entry queue, then popped by the parser, which updates its state
// and loads the output register unless the output stalls. The queue lets
// input keep flowing for up to two bytes while the output is stalled. The
// user must write max_records (cfg_wr_en/cfg_wr_data) only while idle; the
// block does not enforce it. Zero acts as one, values above 256 as 256.
module server_list_response_parser import slrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_valid,
  output logic [31:0] out_server_ip,
  output logic [15:0] out_query_port,
  output logic [15:0] out_game_port,
  output logic [8:0]  out_record_count,
  output logic        out_packet_done,
  output logic [1:0]  out_stop_reason
);

  logic  q_full;
  logic  q_push;
  item_t q_item;
  logic  q_pop;
  logic  q_head_valid;
  item_t q_head_item;

  slrp_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  slrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  slrp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .head_valid       (q_head_valid),
    .head_item        (q_head_item),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_valid (out_record_valid),
    .out_server_ip    (out_server_ip),
    .out_query_port   (out_query_port),
    .out_game_port    (out_game_port),
    .out_record_count (out_record_count),
    .out_packet_done  (out_packet_done),
    .out_stop_reason  (out_stop_reason)
  );

endmodule
